### sv/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types and codes for the row-wise sparse matrix multiplier.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACT_W = 2;

  localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STREAM  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR_B = 2'd2;

  // One partial product travelling down the chain of accumulator cells.
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] val;
  } tok_t;

endpackage

### sv/smm_cell.sv
// ----------------------------------------------------------------------------
// smm_cell
// One accumulator column. Passes the product token on to its neighbor every
// cycle and adds it in when the token's column matches. Shifts toward the
// chain head during row emission.
// ----------------------------------------------------------------------------
module smm_cell
  import smm_pkg::*;
#(
  parameter int unsigned COL = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  input  logic             shift_i,
  input  logic [VAL_W-1:0] acc_i,
  output logic [VAL_W-1:0] acc_o
);

  logic [VAL_W-1:0] acc_q, acc_d;
  logic             tok_vld_q;
  logic [IDX_W-1:0] tok_col_q;
  logic [VAL_W-1:0] tok_val_q;

  always_comb begin
    acc_d = acc_q;
    if (shift_i) begin
      acc_d = acc_i;
    end else if (tok_i.vld && (tok_i.col == IDX_W'(COL))) begin
      acc_d = acc_q + tok_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      tok_vld_q <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      tok_vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_col_q <= tok_i.col;
    tok_val_q <= tok_i.val;
  end

  assign tok_o = '{vld: tok_vld_q, col: tok_col_q, val: tok_val_q};
  assign acc_o = acc_q;

endmodule

### sv/sparse_matrix_multiply.sv
// ----------------------------------------------------------------------------
// sparse_matrix_multiply
// Row-wise sparse product C = A * B on triplet words, accumulated in a chain
// of per-column cells.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, action_i .. row_end_i | into block
//  out     | out_valid_o, out_stall_i, out_row_o .. row_last_o | out of block
//  config  | psel_i, penable_i, pwrite_i, paddr_i, pwdata_i, prdata_o, pready_o
//
// A load or clear word is handled in the idle state. A stream word whose
// column k selects a B row with n stored entries reads those n entries and
// then waits in a flush state while the last product walks the cell chain.
// A row-end word adds an emission scan over the MAX_DIM columns, which
// output stalls lengthen. Reset empties the B store and zeroes every
// accumulator at once; no clearing pass is needed.
//
// B is held in a compressed-row form: per row a {start, end} pair in a small
// memory with one valid bit per row, and the column/value pairs in a second
// memory indexed by the running entry count. For a stream word the sequencer
// reads the row's entries one per cycle, multiplies by the A value, and drops
// each product into the head of the cell chain. Every cell forwards the token
// to its neighbor each cycle and adds it when the column matches its own.
// On a row end the chain is drained, then shifted toward the head once per
// cycle unless a result waits on a stalled output; nonzero head columns
// under the column count are emitted. One result is held back in a pending
// register to mark the row's last; shifting in zeros clears the accumulators.
// ----------------------------------------------------------------------------
module sparse_matrix_multiply
  import smm_pkg::*;
#(
  parameter int unsigned MAX_DIM = 64,
  parameter int unsigned MAX_NZ  = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input words.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [IDX_W-1:0]  row_i,
  input  logic [IDX_W-1:0]  col_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic              row_end_i,
  // Result words.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  out_row_o,
  output logic [IDX_W-1:0]  out_col_o,
  output logic signed [VAL_W-1:0] out_value_o,
  output logic              row_last_o,
  // Configuration port.
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [2:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);

  localparam int unsigned DW = $clog2(MAX_DIM);
  localparam int unsigned NW = $clog2(MAX_NZ);
  localparam int unsigned CW = $clog2(MAX_NZ + 1);
  localparam int unsigned FW = $clog2(MAX_DIM + 6);
  localparam logic [IDX_W:0]  MaxDim = (IDX_W+1)'(MAX_DIM);
  localparam logic [CW-1:0]   MaxNz  = CW'(MAX_NZ);
  localparam logic [FW-1:0]   FlushLen = FW'(MAX_DIM + 4);
  localparam logic [DW-1:0]   LastCol  = DW'(MAX_DIM - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RNG, S_RD, S_FLUSH, S_EMIT, S_FIN
  } state_e;

  // ---------------- configuration ----------------
  logic [6:0] cols_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 7'd64;
    end else if (psel_i && penable_i && pwrite_i && !paddr_i[2]) begin
      cols_q <= pwdata_i[6:0];
    end
  end
  assign pready_o = 1'b1;
  assign prdata_o = paddr_i[2] ? 32'd0 : {25'd0, cols_q};

  // ---------------- control state ----------------
  state_e          state_q;
  logic            in_acc;
  logic [CW-1:0]   b_count_q;
  logic [IDX_W-1:0] last_row_q;
  logic            have_row_q;
  logic [CW-1:0]   cur_start_q;
  logic [MAX_DIM-1:0] row_vld_q;
  logic [CW-1:0]   q_q, hi_q;
  logic [FW-1:0]   flush_q;
  logic [DW-1:0]   scan_q;
  logic            a_ok_q, a_end_q;
  logic [IDX_W-1:0] a_row_q;
  logic [VAL_W-1:0] a_val_q;
  logic            pend_v_q;
  logic [IDX_W-1:0] pend_col_q;
  logic [VAL_W-1:0] pend_val_q;
  logic            out_v_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Load acceptance for B triplets.
  logic load_ok, new_row;
  assign new_row = !have_row_q || (row_i != last_row_q);
  assign load_ok = (action_i == ACT_LOAD_B) && (b_count_q < MaxNz)
                   && ({1'b0, row_i} < MaxDim) && ({1'b0, col_i} < MaxDim)
                   && !(have_row_q && (row_i < last_row_q));

  // ---------------- B store memories ----------------
  logic [2*CW-1:0]  row_mem [MAX_DIM];
  logic [2*CW-1:0]  row_rd_q;
  logic [IDX_W-1:0] nz_col_mem [MAX_NZ];
  logic [VAL_W-1:0] nz_val_mem [MAX_NZ];
  logic [IDX_W-1:0] nz_col_rd_q;
  logic [VAL_W-1:0] nz_val_rd_q;
  logic [CW-1:0]    wr_start;
  logic             rd_issue;

  assign wr_start = new_row ? b_count_q : cur_start_q;
  assign rd_issue = (state_q == S_RD) && (q_q < hi_q);

  always_ff @(posedge clk_i) begin
    if (in_acc && load_ok) begin
      row_mem[row_i[DW-1:0]]       <= {wr_start, b_count_q + CW'(1)};
      nz_col_mem[b_count_q[NW-1:0]] <= col_i;
      nz_val_mem[b_count_q[NW-1:0]] <= value_i;
    end
    row_rd_q    <= row_mem[col_i[DW-1:0]];
    nz_col_rd_q <= nz_col_mem[q_q[NW-1:0]];
    nz_val_rd_q <= nz_val_mem[q_q[NW-1:0]];
  end

  // ---------------- multiply stage feeding the chain ----------------
  logic             rd_v_q;
  logic             head_vld_q;
  logic [IDX_W-1:0] head_col_q;
  logic [VAL_W-1:0] head_val_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q     <= 1'b0;
      head_vld_q <= 1'b0;
    end else begin
      rd_v_q     <= rd_issue;
      head_vld_q <= rd_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    head_col_q <= nz_col_rd_q;
    head_val_q <= VAL_W'(a_val_q * nz_val_rd_q);
  end

  // ---------------- cell chain ----------------
  tok_t             tok [MAX_DIM+1];
  logic [VAL_W-1:0] acc [MAX_DIM+1];
  logic             shift;

  assign tok[0]       = '{vld: head_vld_q, col: head_col_q, val: head_val_q};
  assign acc[MAX_DIM] = '0;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    smm_cell #(.COL(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .shift_i (shift),
      .acc_i   (acc[g+1]),
      .acc_o   (acc[g])
    );
  end

  // ---------------- emission control ----------------
  logic hit, out_free, step, push_mid, push_fin;
  assign out_free = !out_v_q || !out_stall_i;
  assign hit      = (acc[0] != '0) && (7'(scan_q) < cols_q);
  assign step     = (state_q == S_EMIT) && !(hit && pend_v_q && !out_free);
  assign shift    = step;
  assign push_mid = step && hit && pend_v_q;
  assign push_fin = (state_q == S_FIN) && pend_v_q && out_free;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      b_count_q   <= '0;
      last_row_q  <= '0;
      have_row_q  <= 1'b0;
      cur_start_q <= '0;
      row_vld_q   <= '0;
      q_q         <= '0;
      hi_q        <= '0;
      flush_q     <= '0;
      scan_q      <= '0;
      a_ok_q      <= 1'b0;
      a_end_q     <= 1'b0;
      a_row_q     <= '0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      if (push_mid || push_fin) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (action_i)
              ACT_LOAD_B: begin
                if (load_ok) begin
                  b_count_q   <= b_count_q + CW'(1);
                  last_row_q  <= row_i;
                  have_row_q  <= 1'b1;
                  cur_start_q <= wr_start;
                  row_vld_q[row_i[DW-1:0]] <= 1'b1;
                end
              end
              ACT_STREAM: begin
                a_ok_q  <= ({1'b0, col_i} < MaxDim) && row_vld_q[col_i[DW-1:0]];
                a_end_q <= row_end_i;
                a_row_q <= row_i;
                a_val_q <= value_i;
                state_q <= S_RNG;
              end
              ACT_CLEAR_B: begin
                b_count_q  <= '0;
                have_row_q <= 1'b0;
                row_vld_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_RNG: begin
          // A row with no stored entry gives an empty range; its pointer
          // entry may never have been written.
          q_q     <= a_ok_q ? row_rd_q[2*CW-1:CW] : '0;
          hi_q    <= a_ok_q ? row_rd_q[CW-1:0] : '0;
          state_q <= S_RD;
        end
        S_RD: begin
          if (rd_issue) begin
            q_q <= q_q + CW'(1);
          end else begin
            flush_q <= '0;
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          flush_q <= flush_q + FW'(1);
          if (flush_q == FlushLen) begin
            scan_q  <= '0;
            state_q <= a_end_q ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (step) begin
            if (hit) begin
              pend_v_q   <= 1'b1;
              pend_col_q <= IDX_W'(scan_q);
              pend_val_q <= acc[0];
            end
            scan_q <= scan_q + DW'(1);
            if (scan_q == LastCol) begin
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!pend_v_q) begin
            state_q <= S_IDLE;
          end else if (push_fin) begin
            pend_v_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (push_mid || push_fin) begin
      out_row_o   <= a_row_q;
      out_col_o   <= pend_col_q;
      out_value_o <= pend_val_q;
      row_last_o  <= push_fin;
    end
  end
  assign out_valid_o = out_v_q;

  // ---------------- assertions ----------------
  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !tok[MAX_DIM].vld)
    else $error("product token still in chain while idle");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("pending result left behind after emission");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_count_q <= MaxNz)
    else $error("B entry count beyond capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_mid || push_fin) |-> !(out_v_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_no_shift_with_tokens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> !head_vld_q)
    else $error("accumulators shifted while products in flight");

endmodule

### verif/tb_sparse_matrix_multiply.sv
// ----------------------------------------------------------------------------
// tb_sparse_matrix_multiply
// Self-checking testbench for the row-wise sparse matrix multiplier.
// The testbench loads B matrices through the word interface, streams rows of
// A and compares every emitted product word, in order, against an internal
// model of the compressed-row store and the per-column accumulators.
// ----------------------------------------------------------------------------
module tb_sparse_matrix_multiply;
  import smm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM = 64;
  localparam int unsigned NZ = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] ADDR_COLS_OF_B = 3'd0;
  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  // One expected product word.
  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
  } product_t;

  // The scoreboard keeps its own copy of the B store, the accumulators and
  // the column count, and queues the product words each input word causes.
  class product_scoreboard;
    logic [10:0] row_start[DIM+1];
    logic [IDX_W-1:0] b_col[NZ];
    logic [VAL_W-1:0] b_val[NZ];
    int unsigned b_count;
    int unsigned last_row;
    logic [VAL_W-1:0] acc[DIM];
    int unsigned cols_of_b;
    product_t pending[$];
    int errors;

    function void reset_state();
      foreach (row_start[i]) row_start[i] = '0;
      foreach (acc[i]) acc[i] = '0;
      b_count = 0;
      last_row = DIM;
      cols_of_b = 64;
      pending.delete();
      errors = 0;
    endfunction

    function void clear_store();
      foreach (row_start[i]) row_start[i] = '0;
      b_count = 0;
      last_row = DIM;
    endfunction

    function void note_input(logic [ACT_W-1:0] act, logic [IDX_W-1:0] r,
                             logic [IDX_W-1:0] c, logic [VAL_W-1:0] v, logic e);
      int unsigned lim;
      int n;
      product_t p;
      if (act == ACT_LOAD_B) begin
        if (b_count >= NZ) return;
        if (last_row != DIM && 32'(r) < last_row) return;
        b_col[b_count] = c;
        b_val[b_count] = v;
        b_count++;
        last_row = 32'(r);
        for (int i = r + 1; i <= DIM; i++) row_start[i] = 11'(b_count);
      end else if (act == ACT_STREAM) begin
        for (int q = int'(row_start[c]); q < int'(row_start[c+1]); q++)
          acc[b_col[q]] = acc[b_col[q]] + v * b_val[q];
        if (e) begin
          lim = (cols_of_b > DIM) ? DIM : cols_of_b;
          n = 0;
          for (int j = 0; j < lim; j++) begin
            if (acc[j] != 0) begin
              p.row = r;
              p.col = IDX_W'(j);
              p.value = acc[j];
              p.last = 1'b0;
              pending.push_back(p);
              n++;
            end
          end
          if (n > 0) pending[pending.size()-1].last = 1'b1;
          foreach (acc[i]) acc[i] = '0;
        end
      end else if (act == ACT_CLEAR_B) begin
        clear_store();
      end
    endfunction

    function void check_product(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                logic [VAL_W-1:0] v, logic l);
      product_t p;
      if (pending.size() == 0) begin
        $display("%t: unexpected word row %0d col %0d value %h last %b",
                 $realtime, r, c, v, l);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (p.row != r || p.col != c || p.value != v || p.last != l) begin
        $display("%t: expected row %0d col %0d value %h last %b,",
                 $realtime, p.row, p.col, p.value, p.last);
        $display("    got row %0d col %0d value %h last %b", r, c, v, l);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ACT_W-1:0] action_i = '0;
  logic [IDX_W-1:0] row_i = '0;
  logic [IDX_W-1:0] col_i = '0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic row_end_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [IDX_W-1:0] out_row_o;
  logic [IDX_W-1:0] out_col_o;
  logic signed [VAL_W-1:0] out_value_o;
  logic row_last_o;
  logic psel_i = 1'b0;
  logic penable_i = 1'b0;
  logic pwrite_i = 1'b0;
  logic [2:0] paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic pready_o;

  product_scoreboard board;
  bit steady;       // When set, neither side idles.
  int unsigned idle_cycles;

  sparse_matrix_multiply DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver stalls with a chance of 31 in a hundred unless steady is set.
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 31);
  end

  // Product words are checked at the edge that accepts them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_product(out_row_o, out_col_o, out_value_o, row_last_o);
  end

  // The watchdog counts cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sparse_matrix_multiply: mismatch");
      $finish;
    end
  end

  // Sends one word, with a random idle gap in front of it. The word is
  // noted in the scoreboard at the edge that accepts it.
  task automatic send_word(logic [ACT_W-1:0] act, logic [IDX_W-1:0] r,
                           logic [IDX_W-1:0] c, logic [VAL_W-1:0] v, logic e);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    row_i <= r;
    col_i <= c;
    value_i <= v;
    row_end_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(act, r, c, v, e);
  endtask

  // The block is quiet once every expected word has come and it takes input.
  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0 || in_stall_o) @(posedge clk_i);
    repeat (2 * DIM + 20) @(posedge clk_i);
  endtask

  task automatic write_cols(logic [6:0] n);
    psel_i <= 1'b1;
    pwrite_i <= 1'b1;
    paddr_i <= ADDR_COLS_OF_B;
    pwdata_i <= {25'd0, n};
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    board.cols_of_b = 32'(n);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(9) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Clears B, then loads random entries with row indices in ascending order.
  task automatic load_random_b(int unsigned rows, int unsigned span);
    int unsigned r;
    send_word(ACT_CLEAR_B, IDX_W'($urandom), IDX_W'($urandom), $urandom, 1'($urandom));
    r = $urandom_range(span - 1);
    repeat (rows) begin
      repeat ($urandom_range(4, 1))
        send_word(ACT_LOAD_B, IDX_W'(r), IDX_W'($urandom_range(span - 1)),
                  rand_value(), 1'($urandom));
      r = r + $urandom_range(2);
      if (r >= span) r = span - 1;
    end
  endtask

  // Streams one row of A, the last word carrying the row end.
  task automatic stream_row(int unsigned terms, int unsigned span);
    logic [IDX_W-1:0] r;
    r = IDX_W'($urandom);
    for (int i = 0; i < terms; i++)
      send_word(ACT_STREAM, r, IDX_W'($urandom_range(span - 1)), rand_value(),
                i == terms - 1);
  endtask

  initial begin
    int unsigned sent;
    logic [6:0] cols;
    board = new();
    board.reset_state();
    steady = 1'b0;
    idle_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: corner indices, extreme values, ordering and ignored
    // words, an empty row and a clear that keeps the accumulators.
    write_cols(7'd64);
    send_word(ACT_LOAD_B, 6'd0, 6'd0, 32'h7fff_ffff, 1'b1);
    send_word(ACT_LOAD_B, 6'd0, 6'd63, 32'h8000_0000, 1'b0);
    send_word(ACT_LOAD_B, 6'd5, 6'd7, 32'd0, 1'b0);
    send_word(ACT_LOAD_B, 6'd3, 6'd2, 32'd9, 1'b0);   // row below the last: ignored
    send_word(ACT_LOAD_B, 6'd63, 6'd63, 32'hffff_ffff, 1'b0);
    send_word(ACT_UNKNOWN, 6'd63, 6'd63, 32'hffff_ffff, 1'b1);
    send_word(ACT_STREAM, 6'd63, 6'd0, 32'hffff_ffff, 1'b0);
    send_word(ACT_STREAM, 6'd63, 6'd63, 32'h8000_0000, 1'b0);
    send_word(ACT_STREAM, 6'd63, 6'd5, 32'd3, 1'b1);
    send_word(ACT_STREAM, 6'd0, 6'd5, 32'd3, 1'b1);    // empty row
    send_word(ACT_STREAM, 6'd1, 6'd0, 32'd2, 1'b0);
    send_word(ACT_CLEAR_B, 6'd0, 6'd0, 32'd0, 1'b1);
    send_word(ACT_STREAM, 6'd1, 6'd0, 32'd2, 1'b1);    // only the kept sums
    send_word(ACT_STREAM, 6'd2, 6'd0, 32'd2, 1'b1);
    go_idle();
    write_cols(7'd1);
    send_word(ACT_LOAD_B, 6'd1, 6'd0, 32'd5, 1'b0);
    send_word(ACT_LOAD_B, 6'd1, 6'd1, 32'd6, 1'b0);
    send_word(ACT_STREAM, 6'd4, 6'd1, 32'd7, 1'b1);
    go_idle();
    write_cols(7'd0);
    send_word(ACT_STREAM, 6'd4, 6'd1, 32'd7, 1'b1);
    go_idle();
    write_cols(7'd127);
    send_word(ACT_STREAM, 6'd4, 6'd1, 32'd7, 1'b1);
    go_idle();

    // Random part: mostly B loads followed by rows of A, in phases with a
    // new column count, a run of phases without idling and some noise words.
    sent = 0;
    while (sent < 500) begin
      case ($urandom_range(5))
        0: cols = 7'd64;
        1: cols = 7'd1;
        default: cols = 7'($urandom_range(64, 1));
      endcase
      write_cols(cols);
      steady = (sent >= 200 && sent < 300);
      load_random_b($urandom_range(8, 2), ($urandom_range(3) == 0) ? 64 : 8);
      sent += 12;
      repeat ($urandom_range(6, 2)) begin
        stream_row($urandom_range(4, 1), ($urandom_range(3) == 0) ? 64 : 8);
        sent += 3;
        if ($urandom_range(7) == 0) begin
          send_word(ACT_W'($urandom_range(3)), IDX_W'($urandom), IDX_W'($urandom),
                    $urandom, 1'($urandom));
          sent++;
        end
      end
      // Pause the sender until every expected word has arrived.
      go_idle();
    end
    steady = 1'b0;

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("sparse_matrix_multiply: match");
    end else begin
      $display("sparse_matrix_multiply: mismatch");
    end
    $finish;
  end

endmodule

### files.f
sv/smm_pkg.sv
sv/smm_cell.sv
sv/sparse_matrix_multiply.sv
verif/tb_sparse_matrix_multiply.sv
